@@ rtl/sbpr_pkg.sv @@
package sbpr_pkg;

    // Frame layout: positions of the bytes that the responder keeps.
    localparam logic [3:0] PosFirst     = 4'd0;
    localparam logic [3:0] PosId        = 4'd2;
    localparam logic [3:0] PosInstr     = 4'd4;
    localparam logic [3:0] PosPosLow    = 4'd6;
    localparam logic [3:0] PosPosHigh   = 4'd7;
    // A count of eight means a write frame waits for its checksum byte.
    localparam logic [3:0] CountAwaitCs = 4'd8;

    localparam logic [7:0] InstrWrite   = 8'h03;
    localparam logic [7:0] InstrRead    = 8'h02;
    localparam logic [7:0] LfsrTaps     = 8'h30;
    localparam logic [7:0] LfsrSeed     = 8'h2F;
    localparam logic [7:0] ReplyHead    = 8'hFF;
    localparam logic [7:0] ReplyLenCode = 8'h04;
    localparam logic [7:0] ReplyZero    = 8'h00;
    // Sum of the constant reply bytes, modulo 256.
    localparam logic [7:0] ReplyBias    = 8'(ReplyHead + ReplyHead + ReplyLenCode + ReplyZero);

    // Reply byte slots.
    localparam logic [2:0] SlotHead0 = 3'd0;
    localparam logic [2:0] SlotHead1 = 3'd1;
    localparam logic [2:0] SlotId    = 3'd2;
    localparam logic [2:0] SlotLen   = 3'd3;
    localparam logic [2:0] SlotZero  = 3'd4;
    localparam logic [2:0] SlotLow   = 3'd5;
    localparam logic [2:0] SlotHigh  = 3'd6;
    localparam logic [2:0] SlotCsum  = 3'd7;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] low;
        logic [7:0] high;
        logic [7:0] csum;
    } reply_t;

endpackage

@@ rtl/servo_bus_position_responder.sv @@
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_command (1), s_rx_byte (8)
// m_        out        m_valid/m_ready    m_tx_byte (8), m_last_byte (1)
//
// A request moves into the input register when accepted and updates the frame state from
// there; a completed read frame passes the reply register and the serializer to the
// output register, then moves one byte per cycle while m_ready is high.
// The eighth byte of a frame waits in the input register until an earlier reply has been
// fully loaded into the output register; all other requests keep flowing.
// Synchronous reset (aresetn, active low) clears frame count, valid bits; reseeds noise.
module servo_bus_position_responder #(
    parameter int MOTOR_COUNT = 18
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_last_byte
);

    import sbpr_pkg::*;

    logic   reply_valid;
    logic   reply_busy;
    reply_t reply;

    // Frame assembly, checksum checks, the position store and the noise generator.
    sbpr_frame #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_rx_byte   (s_rx_byte),
        .reply_busy  (reply_busy),
        .reply_valid (reply_valid),
        .reply       (reply)
    );

    // The reply serializer holds one reply and feeds the output register.
    sbpr_reply u_reply (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .reply_valid (reply_valid),
        .reply       (reply),
        .reply_busy  (reply_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tx_byte   (m_tx_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

@@ rtl/sbpr_ram.sv @@
module sbpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 18,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sbpr_frame.sv @@
module sbpr_frame #(
    parameter int MOTOR_COUNT = 18
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_command,
    input  logic [7:0]      s_rx_byte,
    input  logic            reply_busy,
    output logic            reply_valid,
    output sbpr_pkg::reply_t reply
);

    import sbpr_pkg::*;

    localparam int AddrW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int VDepth = 1 << AddrW;
    localparam logic [7:0] IdLimit = 8'(MOTOR_COUNT);

    logic             in_valid_reg;
    logic             in_cmd_reg;
    logic [7:0]       in_byte_reg;
    logic [3:0]       count_reg;
    logic [3:0]       count_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       id_reg;
    logic [7:0]       instr_reg;
    logic [7:0]       low_reg;
    logic [7:0]       high_reg;
    logic [7:0]       lfsr_reg;
    logic [7:0]       lfsr_next;
    logic [VDepth-1:0] valid_reg;
    logic             rd_valid_reg;

    logic             consume;
    logic             byte_in;
    logic [7:0]       sum_with;
    logic             id_ok;
    logic             pos_we;
    logic             do_reply;
    logic [AddrW-1:0] addr;
    logic [15:0]      rd_data;
    logic [15:0]      pos;

    // A byte that may complete a read frame waits while a reply is still going out.
    assign consume  = in_valid_reg && !(reply_busy && !in_cmd_reg && count_reg == PosPosHigh);
    assign s_ready  = !in_valid_reg || consume;
    assign byte_in  = consume && !in_cmd_reg;
    assign sum_with = sum_reg + in_byte_reg;
    assign id_ok    = id_reg < IdLimit;
    assign addr     = id_reg[AddrW-1:0];

    assign pos_we   = byte_in && count_reg == CountAwaitCs && sum_with == 8'h00 && id_ok;
    assign do_reply = byte_in && count_reg == PosPosHigh && instr_reg == InstrRead
                      && sum_with == 8'h00 && id_ok;

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (consume) begin
            if (in_cmd_reg || count_reg == CountAwaitCs) begin
                count_next = PosFirst;
            end else if (count_reg == PosPosHigh) begin
                count_next = (instr_reg == InstrWrite) ? CountAwaitCs : PosFirst;
                sum_next   = sum_with;
            end else begin
                count_next = count_reg + 4'd1;
                sum_next   = (count_reg == PosFirst) ? in_byte_reg : sum_with;
            end
        end
    end

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LfsrTaps) : (lfsr_reg >> 1);

    sbpr_ram #(
        .WIDTH (16),
        .DEPTH (MOTOR_COUNT)
    ) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (addr),
        .wdata ({high_reg, low_reg}),
        .raddr (addr),
        .rdata (rd_data)
    );

    assign pos = rd_valid_reg ? rd_data : 16'h0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            count_reg    <= PosFirst;
            lfsr_reg     <= LfsrSeed;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            reply_valid  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            count_reg    <= count_next;
            rd_valid_reg <= valid_reg[addr];
            if (pos_we) begin
                valid_reg[addr] <= 1'b1;
            end
            if (do_reply) begin
                lfsr_reg <= lfsr_next;
            end
            reply_valid <= do_reply;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_command;
            in_byte_reg <= s_rx_byte;
        end
        sum_reg <= sum_next;
        if (byte_in) begin
            case (count_reg)
                PosId:      id_reg    <= in_byte_reg;
                PosInstr:   instr_reg <= in_byte_reg;
                PosPosLow:  low_reg   <= in_byte_reg;
                PosPosHigh: high_reg  <= in_byte_reg;
                default: ;
            endcase
        end
        if (do_reply) begin
            reply.id   <= id_reg;
            reply.low  <= pos[7:0] + lfsr_next;
            reply.high <= pos[15:8];
            reply.csum <= ~(ReplyBias + id_reg + 8'(pos[7:0] + lfsr_next));
        end
    end

endmodule

@@ rtl/sbpr_reply.sv @@
module sbpr_reply (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             reply_valid,
    input  sbpr_pkg::reply_t reply,
    output logic             reply_busy,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_tx_byte,
    output logic             m_last_byte
);

    import sbpr_pkg::*;

    logic       busy_reg;
    logic [2:0] slot_reg;
    reply_t     rep_reg;
    logic       m_valid_reg;
    logic [7:0] m_tx_byte_reg;
    logic       m_last_byte_reg;
    logic       load;
    logic [7:0] slot_byte;

    assign load = busy_reg && (!m_valid_reg || m_ready);

    always_comb begin
        case (slot_reg)
            SlotHead0: slot_byte = ReplyHead;
            SlotHead1: slot_byte = ReplyHead;
            SlotId:    slot_byte = rep_reg.id;
            SlotLen:   slot_byte = ReplyLenCode;
            SlotZero:  slot_byte = ReplyZero;
            SlotLow:   slot_byte = rep_reg.low;
            SlotHigh:  slot_byte = rep_reg.high;
            SlotCsum:  slot_byte = rep_reg.csum;
            default:   slot_byte = ReplyZero;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            slot_reg    <= SlotHead0;
            m_valid_reg <= 1'b0;
        end else begin
            if (reply_valid) begin
                busy_reg <= 1'b1;
                slot_reg <= SlotHead0;
            end else if (load) begin
                slot_reg <= slot_reg + 3'd1;
                if (slot_reg == SlotCsum) begin
                    busy_reg <= 1'b0;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (reply_valid) begin
            rep_reg <= reply;
        end
        if (load) begin
            m_tx_byte_reg   <= slot_byte;
            m_last_byte_reg <= (slot_reg == SlotCsum);
        end
    end

    assign reply_busy  = busy_reg;
    assign m_valid     = m_valid_reg;
    assign m_tx_byte   = m_tx_byte_reg;
    assign m_last_byte = m_last_byte_reg;

endmodule

@@ verif/tb_servo_bus_position_responder.sv @@
`timescale 1ns / 1ps

module tb_servo_bus_position_responder;

    import sbpr_pkg::*;

    localparam int MotorCount = 18;

    // Request codes on s_command.
    localparam logic CmdByte    = 1'b0;
    localparam logic CmdTimeout = 1'b1;

    // A read reply is always eight bytes long.
    localparam int ReplyLen = 8;

    // Minimum number of random requests queued per idling phase.
    localparam int PhaseRequests = 16;

    typedef struct {
        logic       command;
        logic [7:0] rx_byte;
    } bus_request_t;

    typedef struct {
        logic [7:0] tx_byte;
        logic       last_byte;
    } reply_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_command = 1'b0;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_last_byte;

    // Requests waiting for the driver, and reply bytes the servo bus should send.
    bus_request_t pending_requests[$];
    reply_byte_t  replies_due[$];

    // Set at each rising edge when the request on the bus was accepted there.
    logic req_taken = 1'b0;

    // Idling in percent, changed between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int mismatch_count = 0;
    int queued_count = 0;

    // Shadow of the responder: frame buffer, fill count, position table and
    // the noise generator that perturbs the low byte of every reply.
    logic [7:0]  frame_buf[ReplyLen];
    logic [3:0]  held_count = '0;
    logic [15:0] stored_pos[MotorCount];
    logic [7:0]  noise_state = LfsrSeed;

    servo_bus_position_responder #(
        .MOTOR_COUNT(MotorCount)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_byte  (m_tx_byte),
        .m_last_byte(m_last_byte)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] frame_checksum();
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < ReplyLen; i++) begin
            acc = acc + frame_buf[i];
        end
        return acc;
    endfunction

    // Builds the eight-byte position reply for one servo id. The noise
    // generator advances exactly once per reply that goes out.
    task automatic queue_position_reply(input logic [7:0] servo_id);
        logic [15:0] pos;
        logic [7:0]  reply[ReplyLen];
        logic [7:0]  acc;
        pos = stored_pos[servo_id];
        noise_state = {1'b0, noise_state[7:1]} ^ (noise_state[0] ? LfsrTaps : 8'h00);
        reply[0] = ReplyHead;
        reply[1] = ReplyHead;
        reply[2] = servo_id;
        reply[3] = ReplyLenCode;
        reply[4] = ReplyZero;
        // The low byte plus noise wraps modulo 256.
        reply[5] = pos[7:0] + noise_state;
        reply[6] = pos[15:8];
        acc = 8'h00;
        for (int i = 0; i < 6; i++) begin
            acc = acc + reply[i];
        end
        reply[7] = ~acc;
        for (int i = 0; i < ReplyLen; i++) begin
            replies_due.push_back('{tx_byte: reply[i], last_byte: (i == ReplyLen - 1)});
        end
    endtask

    // Applies one accepted request to the shadow state.
    task automatic track_request(input logic command, input logic [7:0] rx_byte);
        logic [7:0] servo_id;
        logic [7:0] total;
        if (command == CmdTimeout) begin
            held_count = '0;
            return;
        end
        // With a full write frame held, this byte is its checksum.
        if (held_count >= CountAwaitCs) begin
            servo_id = frame_buf[PosId];
            total = frame_checksum() + rx_byte;
            held_count = '0;
            if (total == 8'h00 && servo_id < MotorCount) begin
                stored_pos[servo_id] = {frame_buf[PosPosHigh], frame_buf[PosPosLow]};
            end
            return;
        end
        frame_buf[held_count[2:0]] = rx_byte;
        held_count = held_count + 4'd1;
        if (held_count < CountAwaitCs) begin
            return;
        end
        // A write frame stays held until its checksum byte arrives.
        if (frame_buf[PosInstr] == InstrWrite) begin
            return;
        end
        held_count = '0;
        servo_id = frame_buf[PosId];
        if (frame_buf[PosInstr] != InstrRead || frame_checksum() != 8'h00
                || servo_id >= MotorCount) begin
            return;
        end
        queue_position_reply(servo_id);
    endtask

    // ------------------------------------------------------------------
    // Driver and monitor
    // ------------------------------------------------------------------

    // Requests and m_ready change on the falling edge only. A new request is
    // put on the bus when the bus is free or the previous one was just taken,
    // so s_valid never drops while a request is waiting.
    always @(negedge aclk) begin : drive_requests
        bus_request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_requests.pop_front();
                s_valid   <= 1'b1;
                s_command <= next_req.command;
                s_rx_byte <= next_req.rx_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    // Everything is sampled on the rising edge. Reply bytes are checked before
    // the request of the same edge is applied; a reply can never leave in the
    // cycle its own request is taken, so the order does not hide anything.
    always @(posedge aclk) begin : watch_bus
        reply_byte_t due;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply byte: tx_byte=%02h last_byte=%b",
                           m_tx_byte, m_last_byte);
                    mismatch_count++;
                end else begin
                    due = replies_due.pop_front();
                    if (m_tx_byte !== due.tx_byte) begin
                        $error("tx_byte mismatch: expected %02h, actual %02h",
                               due.tx_byte, m_tx_byte);
                        mismatch_count++;
                    end
                    if (m_last_byte !== due.last_byte) begin
                        $error("last_byte mismatch: expected %b, actual %b",
                               due.last_byte, m_last_byte);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                track_request(s_command, s_rx_byte);
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame builders
    // ------------------------------------------------------------------

    task automatic push_request(input logic command, input logic [7:0] rx_byte);
        pending_requests.push_back('{command: command, rx_byte: rx_byte});
        queued_count++;
    endtask

    task automatic push_timeout();
        push_request(CmdTimeout, 8'($urandom));
    endtask

    // Read frame: bytes 0..6 are free apart from the id and the instruction,
    // byte 7 balances the sum to zero. A corrupt frame is off by a nonzero amount.
    task automatic push_read_frame(input logic [7:0] servo_id, input bit corrupt);
        logic [7:0] frame[ReplyLen];
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < ReplyLen - 1; i++) begin
            frame[i] = ($urandom_range(3) == 0) ? 8'($urandom) : ReplyHead;
        end
        frame[PosId] = servo_id;
        frame[PosInstr] = InstrRead;
        for (int i = 0; i < ReplyLen - 1; i++) begin
            acc = acc + frame[i];
        end
        frame[7] = 8'h00 - acc;
        if (corrupt) begin
            frame[7] = frame[7] + 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < ReplyLen; i++) begin
            push_request(CmdByte, frame[i]);
        end
    endtask

    // Write frame: eight bytes carrying id, instruction and position, then
    // a ninth byte that brings the sum of all nine to zero.
    task automatic push_write_frame(input logic [7:0] servo_id, input logic [15:0] pos,
                                    input bit corrupt);
        logic [7:0] frame[ReplyLen];
        logic [7:0] acc;
        logic [7:0] check;
        acc = 8'h00;
        for (int i = 0; i < ReplyLen; i++) begin
            frame[i] = ($urandom_range(3) == 0) ? 8'($urandom) : ReplyHead;
        end
        frame[PosId] = servo_id;
        frame[PosInstr] = InstrWrite;
        frame[PosPosLow] = pos[7:0];
        frame[PosPosHigh] = pos[15:8];
        for (int i = 0; i < ReplyLen; i++) begin
            acc = acc + frame[i];
            push_request(CmdByte, frame[i]);
        end
        check = 8'h00 - acc;
        if (corrupt) begin
            check = check + 8'($urandom_range(255, 1));
        end
        push_request(CmdByte, check);
    endtask

    // Eight bytes whose instruction is neither read nor write.
    task automatic push_other_frame(input logic [7:0] instr);
        for (int i = 0; i < ReplyLen; i++) begin
            if (i == PosInstr) begin
                push_request(CmdByte, instr);
            end else begin
                push_request(CmdByte, 8'($urandom));
            end
        end
    endtask

    function automatic logic [7:0] pick_servo_id();
        // Mostly ids the responder serves, sometimes ones it must ignore.
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(255, MotorCount));
        end
        return 8'($urandom_range(MotorCount - 1));
    endfunction

    // Waits until the driver has handed every queued request to the block.
    task automatic wait_requests_taken();
        while (pending_requests.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : run_stimulus
        int unsigned idle_by_phase[4];
        int unsigned stall_by_phase[4];
        int          phase_start;
        int unsigned pick;
        int unsigned run_len;
        logic [7:0]  instr;

        idle_by_phase  = '{0, 88, 0, 35};
        stall_by_phase = '{0, 0, 88, 35};
        for (int i = 0; i < MotorCount; i++) begin
            stored_pos[i] = 16'h0000;
        end
        for (int i = 0; i < ReplyLen; i++) begin
            frame_buf[i] = 8'h00;
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, with no idling on either side.
        // A read of an id never written returns position zero.
        push_read_frame(8'd0, 1'b0);
        // Top position at the top id, then read back: the low byte plus the
        // noise wraps around.
        push_write_frame(8'(MotorCount - 1), 16'hFFFF, 1'b0);
        push_read_frame(8'(MotorCount - 1), 1'b0);
        // Ids just past the table and at the top of the byte are ignored.
        push_write_frame(8'(MotorCount), 16'h1234, 1'b0);
        push_read_frame(8'(MotorCount), 1'b0);
        push_read_frame(8'hFF, 1'b0);
        // Bad checksums drop the frame without touching the table or the noise.
        push_write_frame(8'd0, 16'hA5A5, 1'b1);
        push_read_frame(8'd0, 1'b1);
        push_read_frame(8'd0, 1'b0);
        // A timeout in the middle of a frame, and one while a write frame
        // waits for its checksum byte.
        push_request(CmdByte, 8'h00);
        push_request(CmdByte, 8'hFF);
        push_timeout();
        push_request(CmdByte, 8'hFF);
        push_request(CmdByte, 8'hFF);
        push_request(CmdByte, 8'd0);
        push_request(CmdByte, 8'h00);
        push_request(CmdByte, InstrWrite);
        push_request(CmdByte, 8'h00);
        push_request(CmdByte, 8'h55);
        push_request(CmdByte, 8'hAA);
        push_timeout();
        // Instructions the responder does not know.
        push_other_frame(8'h00);
        push_other_frame(8'hFF);
        // The dropped write above must have left position zero at id 0.
        push_read_frame(8'd0, 1'b0);
        wait_requests_taken();

        // Random part in four phases of idling. Most requests form well-built
        // frames so that writes land and reads return them; the rest are
        // corrupted frames, unknown instructions, stray bytes and timeouts.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            phase_start = queued_count;
            while (queued_count - phase_start < PhaseRequests) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    push_write_frame(pick_servo_id(), 16'($urandom), 1'b0);
                end else if (pick < 75) begin
                    push_read_frame(pick_servo_id(), 1'b0);
                end else if (pick < 82) begin
                    push_read_frame(pick_servo_id(), 1'b1);
                end else if (pick < 88) begin
                    push_write_frame(pick_servo_id(), 16'($urandom), 1'b1);
                end else if (pick < 93) begin
                    // Partial frame cut off by a timeout; eight bytes with a
                    // write instruction leave it waiting for the checksum.
                    run_len = $urandom_range(ReplyLen, 1);
                    for (int i = 0; i < run_len; i++) begin
                        push_request(CmdByte, (i == PosInstr) ? InstrWrite : 8'($urandom));
                    end
                    push_timeout();
                end else if (pick < 97) begin
                    do begin
                        instr = 8'($urandom);
                    end while (instr == InstrRead || instr == InstrWrite);
                    push_other_frame(instr);
                end else begin
                    // Raw noise on the line, then a timeout to resynchronize.
                    run_len = $urandom_range(6, 1);
                    for (int i = 0; i < run_len; i++) begin
                        push_request(1'($urandom), 8'($urandom));
                    end
                    push_timeout();
                end
            end
            wait_requests_taken();
        end

        // Let the last replies drain, then keep watching the bus in case
        // anything stray follows.
        while (replies_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin : watchdog
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sbpr_pkg.sv
rtl/sbpr_ram.sv
rtl/sbpr_frame.sv
rtl/sbpr_reply.sv
rtl/servo_bus_position_responder.sv
verif/tb_servo_bus_position_responder.sv
